>>> design/psp_pkg.sv
// Shared types and constants for the pixmap stream parser.
package psp_pkg;

	// Parse phases of the byte stream.
	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_WIDTH,
		PH_HEIGHT,
		PH_MAXIMUM,
		PH_TEXT_RASTER,
		PH_BIN_RASTER,
		PH_TRAILER,
		PH_DONE
	} phase_t;

	// Controller states.
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_STEP,
		CS_DIV,
		CS_OUT0,
		CS_OUT1
	} ctl_state_t;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER   = 2'd0;
	localparam logic [1:0] KIND_PIXEL    = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;
	localparam logic [1:0] KIND_COMPLETE = 2'd3;

	// Fault codes.
	localparam logic [2:0] FLT_MAGIC     = 3'd1;
	localparam logic [2:0] FLT_NUMBER    = 3'd2;
	localparam logic [2:0] FLT_MISSING   = 3'd3;
	localparam logic [2:0] FLT_DIMENSION = 3'd4;
	localparam logic [2:0] FLT_OVER_MAX  = 3'd5;
	localparam logic [2:0] FLT_TRUNCATED = 3'd6;
	localparam logic [2:0] FLT_TRAILING  = 3'd7;

	// Numeric limits.
	localparam logic [24:0] WORD_SAT     = 25'h1FF_FFFF;
	localparam logic [24:0] PIXEL_CAP    = 25'h100_0000;
	localparam logic [24:0] SAMPLE_CEIL  = 25'd65535;
	localparam logic [4:0]  DIV_LAST     = 5'd16;

	// Special characters.
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_3    = 8'h33;
	localparam logic [7:0] CH_6    = 8'h36;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;

	// One result.
	typedef struct packed {
		logic [1:0]  kind;
		logic [24:0] wid;
		logic [24:0] hgt;
		logic [15:0] maxv;
		logic [16:0] red;
		logic [16:0] grn;
		logic [16:0] blu;
		logic [2:0]  code;
	} res_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic step;
		logic sel;
	} psp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [1:0] new_cnt;
		logic       new_pix;
		logic [1:0] cnt;
		logic       div_busy;
	} psp_stat_t;

endpackage

>>> design/psp_ctrl.sv
// Controller state machine of the pixmap stream parser.
module psp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  psp_pkg::psp_stat_t   st,
	output psp_pkg::psp_cmd_t    cmd
);

	psp_pkg::ctl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psp_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			psp_pkg::CS_IDLE: begin
				if (in_valid) state_d = psp_pkg::CS_STEP;
			end
			psp_pkg::CS_STEP: begin
				if (st.new_cnt == 2'd0) state_d = psp_pkg::CS_IDLE;
				else if (st.new_pix) state_d = psp_pkg::CS_DIV;
				else state_d = psp_pkg::CS_OUT0;
			end
			psp_pkg::CS_DIV: begin
				if (!st.div_busy) state_d = psp_pkg::CS_OUT0;
			end
			psp_pkg::CS_OUT0: begin
				if (!out_stall) begin
					state_d = (st.cnt == 2'd2) ? psp_pkg::CS_OUT1 : psp_pkg::CS_IDLE;
				end
			end
			psp_pkg::CS_OUT1: begin
				if (!out_stall) state_d = psp_pkg::CS_IDLE;
			end
			default: state_d = psp_pkg::CS_IDLE;
		endcase
	end

	// Outputs and commands.
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			psp_pkg::CS_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			psp_pkg::CS_STEP: begin
				cmd.step = 1'b1;
			end
			psp_pkg::CS_OUT0: begin
				out_valid = 1'b1;
			end
			psp_pkg::CS_OUT1: begin
				out_valid = 1'b1;
				cmd.sel   = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> design/psp_datapath.sv
// Datapath of the pixmap stream parser: parse state, result slots and level divider.
module psp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  psp_pkg::psp_cmd_t   cmd,
	output psp_pkg::psp_stat_t  st,
	input  logic [7:0]          data_byte,
	input  logic                end_of_file,
	input  logic                cfg_we,
	input  logic [24:0]         cfg_data,
	output logic [1:0]          result_kind,
	output logic [24:0]         image_width,
	output logic [24:0]         image_height,
	output logic [15:0]         sample_maximum,
	output logic [16:0]         red_level,
	output logic [16:0]         green_level,
	output logic [16:0]         blue_level,
	output logic [2:0]          fault_code,
	output logic                last_result
);

	// Input request and configuration.
	logic [7:0]  byte_q;
	logic        eof_q;
	logic [24:0] limit_q;

	// Parse state.
	psp_pkg::phase_t phase_q, n_phase;
	logic        bin_q, n_bin;
	logic        cmt_q, n_cmt;
	logic        tok_q, n_tok;
	logic [24:0] val_q, n_val;
	logic [24:0] wid_q, n_wid;
	logic [24:0] hgt_q, n_hgt;
	logic [15:0] max_q, n_max;
	logic [24:0] left_q, n_left;
	logic [1:0]  chan_q, n_chan;
	logic [15:0] red_q, n_red;
	logic [15:0] grn_q, n_grn;
	logic [8:0]  hb_q, n_hb;
	logic        cr_q, n_cr;
	logic        flt_q, n_flt;
	logic [49:0] area_q;

	// Result slots.
	psp_pkg::res_t slot_q [2];
	psp_pkg::res_t n_slots [2];
	logic [1:0]    cnt_q, n_cnt;

	// Divider.
	logic        div_busy_q;
	logic [1:0]  dch_q;
	logic [4:0]  dcnt_q;
	logic [15:0] drem_q;
	logic [16:0] dlow_q;
	logic [16:0] dquo_q;
	logic [15:0] dmax_q;

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= psp_pkg::PIXEL_CAP;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// Input request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= data_byte;
			eof_q  <= end_of_file;
		end
	end

	// Image area, stable long before the maximum word ends.
	always_ff @(posedge clk) begin
		area_q <= wid_q * hgt_q;
	end

	// One byte of parsing.
	always_comb begin
		psp_pkg::res_t e;
		logic        is_sp;
		logic        ew;
		logic        ew_sp;
		logic        ew_cr;
		logic        ts;
		logic [24:0] ts_v;
		logic        hash;
		logic        skip;
		logic [28:0] nv;
		logic [24:0] v;
		logic [24:0] lim;

		n_phase = phase_q;
		n_bin   = bin_q;
		n_cmt   = cmt_q;
		n_tok   = tok_q;
		n_val   = val_q;
		n_wid   = wid_q;
		n_hgt   = hgt_q;
		n_max   = max_q;
		n_left  = left_q;
		n_chan  = chan_q;
		n_red   = red_q;
		n_grn   = grn_q;
		n_hb    = hb_q;
		n_cr    = cr_q;
		n_flt   = flt_q;
		n_cnt   = 2'd0;
		n_slots[0] = '0;
		n_slots[1] = '0;
		e     = '0;
		ew    = 1'b0;
		ew_sp = 1'b0;
		ew_cr = 1'b0;
		ts    = 1'b0;
		ts_v  = '0;
		hash  = 1'b0;
		skip  = 1'b0;
		nv    = '0;
		v     = '0;
		lim   = (limit_q > psp_pkg::PIXEL_CAP) ? psp_pkg::PIXEL_CAP : limit_q;
		is_sp = byte_q inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0C, 8'h0B};

		// Byte handling, raw raster or text.
		if (!n_flt) begin
			if (n_phase == psp_pkg::PH_BIN_RASTER || n_phase == psp_pkg::PH_DONE) begin
				if (n_phase == psp_pkg::PH_DONE) begin
					e = '0;
					e.kind = psp_pkg::KIND_ERROR;
					e.code = psp_pkg::FLT_TRAILING;
					if (n_cnt != 2'd2) begin
						n_slots[n_cnt[0]] = e;
						n_cnt = n_cnt + 2'd1;
					end
					n_flt = 1'b1;
				end else begin
					if (n_cr) begin
						n_cr = 1'b0;
						if (byte_q == psp_pkg::CH_LF) skip = 1'b1;
					end
					if (!skip) begin
						if (max_q < 16'd256) begin
							ts   = 1'b1;
							ts_v = {17'd0, byte_q};
						end else if (!n_hb[8]) begin
							n_hb = {1'b1, byte_q};
						end else begin
							ts   = 1'b1;
							ts_v = {9'd0, n_hb[7:0], byte_q};
							n_hb = '0;
						end
					end
				end
			end else if (n_cmt) begin
				if (byte_q == psp_pkg::CH_LF || byte_q == psp_pkg::CH_CR) n_cmt = 1'b0;
			end else if (is_sp || byte_q == psp_pkg::CH_HASH) begin
				if (n_tok) begin
					ew    = 1'b1;
					ew_sp = is_sp;
					ew_cr = (byte_q == psp_pkg::CH_CR);
				end
				hash = (byte_q == psp_pkg::CH_HASH);
			end else if (n_phase == psp_pkg::PH_TRAILER) begin
				e = '0;
				e.kind = psp_pkg::KIND_ERROR;
				e.code = psp_pkg::FLT_TRAILING;
				if (n_cnt != 2'd2) begin
					n_slots[n_cnt[0]] = e;
					n_cnt = n_cnt + 2'd1;
				end
				n_flt = 1'b1;
			end else begin
				// Character inside a word.
				n_tok = 1'b1;
				if (n_phase == psp_pkg::PH_MAGIC) begin
					if (n_val == 25'd0 && byte_q == psp_pkg::CH_P) n_val = 25'd1;
					else if (n_val == 25'd1 && byte_q == psp_pkg::CH_3) n_val = 25'd2;
					else if (n_val == 25'd1 && byte_q == psp_pkg::CH_6) n_val = 25'd3;
					else begin
						e = '0;
						e.kind = psp_pkg::KIND_ERROR;
						e.code = psp_pkg::FLT_MAGIC;
						if (n_cnt != 2'd2) begin
							n_slots[n_cnt[0]] = e;
							n_cnt = n_cnt + 2'd1;
						end
						n_flt = 1'b1;
					end
				end else if (byte_q < psp_pkg::CH_0 || byte_q > psp_pkg::CH_9) begin
					e = '0;
					e.kind = psp_pkg::KIND_ERROR;
					e.code = psp_pkg::FLT_NUMBER;
					if (n_cnt != 2'd2) begin
						n_slots[n_cnt[0]] = e;
						n_cnt = n_cnt + 2'd1;
					end
					n_flt = 1'b1;
				end else begin
					nv = ({4'd0, n_val} << 3) + ({4'd0, n_val} << 1) + {25'd0, byte_q[3:0]};
					if (nv > {4'd0, psp_pkg::WORD_SAT}) n_val = psp_pkg::WORD_SAT;
					else n_val = nv[24:0];
				end
			end
		end

		// End of file closes an open word.
		if (eof_q && !n_flt && n_tok && !ew) begin
			ew    = 1'b1;
			ew_sp = 1'b0;
			ew_cr = 1'b0;
		end

		// Word complete.
		if (ew) begin
			v     = n_val;
			n_tok = 1'b0;
			n_val = '0;
			case (n_phase)
				psp_pkg::PH_MAGIC: begin
					if (v == 25'd2 || v == 25'd3) begin
						n_bin   = (v == 25'd3);
						n_phase = psp_pkg::PH_WIDTH;
					end else begin
						e = '0;
						e.kind = psp_pkg::KIND_ERROR;
						e.code = psp_pkg::FLT_MAGIC;
						if (n_cnt != 2'd2) begin
							n_slots[n_cnt[0]] = e;
							n_cnt = n_cnt + 2'd1;
						end
						n_flt = 1'b1;
					end
				end
				psp_pkg::PH_WIDTH: begin
					n_wid   = v;
					n_phase = psp_pkg::PH_HEIGHT;
				end
				psp_pkg::PH_HEIGHT: begin
					n_hgt   = v;
					n_phase = psp_pkg::PH_MAXIMUM;
				end
				psp_pkg::PH_MAXIMUM: begin
					if (wid_q == 25'd0 || hgt_q == 25'd0 || v == 25'd0 ||
					    v > psp_pkg::SAMPLE_CEIL || area_q > {25'd0, lim}) begin
						e = '0;
						e.kind = psp_pkg::KIND_ERROR;
						e.code = psp_pkg::FLT_DIMENSION;
						if (n_cnt != 2'd2) begin
							n_slots[n_cnt[0]] = e;
							n_cnt = n_cnt + 2'd1;
						end
						n_flt = 1'b1;
					end else begin
						n_max  = v[15:0];
						n_left = area_q[24:0];
						e = '0;
						e.kind = psp_pkg::KIND_HEADER;
						e.wid  = wid_q;
						e.hgt  = hgt_q;
						e.maxv = v[15:0];
						if (n_cnt != 2'd2) begin
							n_slots[n_cnt[0]] = e;
							n_cnt = n_cnt + 2'd1;
						end
						if (!n_bin) begin
							n_phase = psp_pkg::PH_TEXT_RASTER;
						end else if (ew_sp) begin
							n_phase = psp_pkg::PH_BIN_RASTER;
							n_cr    = ew_cr;
						end else begin
							e = '0;
							e.kind = psp_pkg::KIND_ERROR;
							e.code = psp_pkg::FLT_TRAILING;
							if (n_cnt != 2'd2) begin
								n_slots[n_cnt[0]] = e;
								n_cnt = n_cnt + 2'd1;
							end
							n_flt = 1'b1;
						end
					end
				end
				psp_pkg::PH_TEXT_RASTER: begin
					ts   = 1'b1;
					ts_v = v;
				end
				default: begin
					n_tok = 1'b0;
				end
			endcase
		end

		// Sample complete.
		if (ts) begin
			if (ts_v > {9'd0, max_q}) begin
				e = '0;
				e.kind = psp_pkg::KIND_ERROR;
				e.code = psp_pkg::FLT_OVER_MAX;
				if (n_cnt != 2'd2) begin
					n_slots[n_cnt[0]] = e;
					n_cnt = n_cnt + 2'd1;
				end
				n_flt = 1'b1;
			end else if (n_chan == 2'd0) begin
				n_red  = ts_v[15:0];
				n_chan = 2'd1;
			end else if (n_chan == 2'd1) begin
				n_grn  = ts_v[15:0];
				n_chan = 2'd2;
			end else begin
				// Raw samples here; the divider turns them into levels.
				e = '0;
				e.kind = psp_pkg::KIND_PIXEL;
				e.red  = {1'b0, red_q};
				e.grn  = {1'b0, grn_q};
				e.blu  = {1'b0, ts_v[15:0]};
				if (n_cnt != 2'd2) begin
					n_slots[n_cnt[0]] = e;
					n_cnt = n_cnt + 2'd1;
				end
				n_chan = 2'd0;
				if (n_left != 25'd0) n_left = n_left - 25'd1;
				if (n_left == 25'd0) begin
					n_phase = n_bin ? psp_pkg::PH_DONE : psp_pkg::PH_TRAILER;
				end
			end
		end

		// A hash outside a word opens a comment.
		if (hash && !n_flt) n_cmt = 1'b1;

		// End of file: final verdict, then rearm.
		if (eof_q) begin
			if (!n_flt) begin
				e = '0;
				case (n_phase)
					psp_pkg::PH_MAGIC, psp_pkg::PH_WIDTH, psp_pkg::PH_HEIGHT,
					psp_pkg::PH_MAXIMUM: begin
						e.kind = psp_pkg::KIND_ERROR;
						e.code = psp_pkg::FLT_MISSING;
					end
					psp_pkg::PH_TEXT_RASTER, psp_pkg::PH_BIN_RASTER: begin
						e.kind = psp_pkg::KIND_ERROR;
						e.code = psp_pkg::FLT_TRUNCATED;
					end
					default: begin
						e.kind = psp_pkg::KIND_COMPLETE;
					end
				endcase
				if (n_cnt != 2'd2) begin
					n_slots[n_cnt[0]] = e;
					n_cnt = n_cnt + 2'd1;
				end
			end
			n_phase = psp_pkg::PH_MAGIC;
			n_bin   = 1'b0;
			n_cmt   = 1'b0;
			n_tok   = 1'b0;
			n_val   = '0;
			n_wid   = '0;
			n_hgt   = '0;
			n_max   = '0;
			n_left  = '0;
			n_chan  = '0;
			n_red   = '0;
			n_grn   = '0;
			n_hb    = '0;
			n_cr    = 1'b0;
			n_flt   = 1'b0;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= psp_pkg::PH_MAGIC;
			bin_q   <= 1'b0;
			cmt_q   <= 1'b0;
			tok_q   <= 1'b0;
			val_q   <= '0;
			wid_q   <= '0;
			hgt_q   <= '0;
			max_q   <= '0;
			left_q  <= '0;
			chan_q  <= '0;
			red_q   <= '0;
			grn_q   <= '0;
			hb_q    <= '0;
			cr_q    <= 1'b0;
			flt_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (cmd.step) begin
			phase_q <= n_phase;
			bin_q   <= n_bin;
			cmt_q   <= n_cmt;
			tok_q   <= n_tok;
			val_q   <= n_val;
			wid_q   <= n_wid;
			hgt_q   <= n_hgt;
			max_q   <= n_max;
			left_q  <= n_left;
			chan_q  <= n_chan;
			red_q   <= n_red;
			grn_q   <= n_grn;
			hb_q    <= n_hb;
			cr_q    <= n_cr;
			flt_q   <= n_flt;
			cnt_q   <= n_cnt;
		end
	end

	// Divider step: one quotient bit per cycle.
	logic [16:0] dtry;
	logic        dge;
	logic [15:0] drem_nx;
	logic [16:0] dquo_nx;
	logic        new_pix;
	logic [15:0] load_s;
	logic [32:0] load_d;
	logic [15:0] dsor;

	assign new_pix = (n_cnt != 2'd0) && (n_slots[0].kind == psp_pkg::KIND_PIXEL);
	assign dsor    = cmd.step ? max_q : dmax_q;
	assign dtry    = {drem_q, dlow_q[16]};
	assign dge     = dtry >= {1'b0, dmax_q};
	assign drem_nx = dge ? 16'(dtry - {1'b0, dmax_q}) : dtry[15:0];
	assign dquo_nx = {dquo_q[15:0], dge};

	// Sample for the next division, with the half-maximum rounding term.
	always_comb begin
		if (cmd.step) load_s = n_slots[0].red[15:0];
		else if (dch_q == 2'd0) load_s = slot_q[0].grn[15:0];
		else load_s = slot_q[0].blu[15:0];
		load_d = {1'b0, load_s, 16'd0} + {18'd0, dsor[15:1]};
	end

	// Divisor held for the whole pixel, since end of file clears the maximum.
	always_ff @(posedge clk) begin
		if (cmd.step) dmax_q <= max_q;
	end

	// Divider control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dch_q      <= '0;
			dcnt_q     <= '0;
		end else if (cmd.step) begin
			div_busy_q <= new_pix;
			dch_q      <= '0;
			dcnt_q     <= '0;
		end else if (div_busy_q) begin
			if (dcnt_q == psp_pkg::DIV_LAST) begin
				dcnt_q <= '0;
				dch_q  <= dch_q + 2'd1;
				if (dch_q == 2'd2) div_busy_q <= 1'b0;
			end else begin
				dcnt_q <= dcnt_q + 5'd1;
			end
		end
	end

	// Divider data.
	always_ff @(posedge clk) begin
		if (cmd.step || (div_busy_q && dcnt_q == psp_pkg::DIV_LAST)) begin
			drem_q <= load_d[32:17];
			dlow_q <= load_d[16:0];
			dquo_q <= '0;
		end else if (div_busy_q) begin
			drem_q <= drem_nx;
			dlow_q <= {dlow_q[15:0], 1'b0};
			dquo_q <= dquo_nx;
		end
	end

	// Result slots, levels filled in by the divider.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			slot_q[0] <= n_slots[0];
			slot_q[1] <= n_slots[1];
		end else if (div_busy_q && dcnt_q == psp_pkg::DIV_LAST) begin
			case (dch_q)
				2'd0:    slot_q[0].red <= dquo_nx;
				2'd1:    slot_q[0].grn <= dquo_nx;
				default: slot_q[0].blu <= dquo_nx;
			endcase
		end
	end

	// Status.
	assign st.new_cnt  = n_cnt;
	assign st.new_pix  = new_pix;
	assign st.cnt      = cnt_q;
	assign st.div_busy = div_busy_q;

	// Result output.
	assign result_kind    = slot_q[cmd.sel].kind;
	assign image_width    = slot_q[cmd.sel].wid;
	assign image_height   = slot_q[cmd.sel].hgt;
	assign sample_maximum = slot_q[cmd.sel].maxv;
	assign red_level      = slot_q[cmd.sel].red;
	assign green_level    = slot_q[cmd.sel].grn;
	assign blue_level     = slot_q[cmd.sel].blu;
	assign fault_code     = slot_q[cmd.sel].code;
	assign last_result    = cmd.sel || (cnt_q == 2'd1);

endmodule

>>> design/pixmap_stream_parser_unit.sv
// Pixmap stream parser: P3/P6 header and pixel reader, top level.
//
// Input channel: one file byte per request (data_byte, end_of_file) on
// in_valid / in_stall. Output channel: header, pixel, error and complete
// results on out_valid / out_stall. Configuration: pixel_limit is written
// over cfg_valid / cfg_ready, which is always ready; write it while idle.
// A byte that gives no result passes a capture step and a parse step; each
// result is then held on the output until it is taken. For a pixel result
// the shared restoring divider forms the three levels one quotient bit per
// cycle, channel after channel; the controller waits for it to finish
// before the pixel result is shown.
// The block takes the next byte only after all results of the previous one
// have been taken; while the receiver stalls, the result and its fields hold
// and the input stays stalled.
// Reset clears the parse state to the start of a file and sets pixel_limit
// to 16777216. After a byte marked end_of_file the parser rearms for a new
// file and keeps pixel_limit.
module pixmap_stream_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [24:0] image_width,
	output logic [24:0] image_height,
	output logic [15:0] sample_maximum,
	output logic [16:0] red_level,
	output logic [16:0] green_level,
	output logic [16:0] blue_level,
	output logic [2:0]  fault_code,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [24:0] pixel_limit
);

	psp_pkg::psp_cmd_t  cmd;
	psp_pkg::psp_stat_t st;

	// Configuration is taken on any cycle.
	assign cfg_ready = 1'b1;

	// Controller.
	psp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath.
	psp_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.data_byte      (data_byte),
		.end_of_file    (end_of_file),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_data       (pixel_limit),
		.result_kind    (result_kind),
		.image_width    (image_width),
		.image_height   (image_height),
		.sample_maximum (sample_maximum),
		.red_level      (red_level),
		.green_level    (green_level),
		.blue_level     (blue_level),
		.fault_code     (fault_code),
		.last_result    (last_result)
	);

endmodule
